[design/tcgw_pkg.sv]
package tcgw_pkg;

  localparam int unsigned MAX_SCREEN_PX = 2048;
  localparam int unsigned PIXEL_BYTES   = 3;
  localparam int unsigned GLYPH_SIZE    = 8;

  localparam int unsigned CFG_W      = 12;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned ROW_W      = 9;
  localparam int unsigned OFF_W      = 24;
  localparam int unsigned PITCH_W    = 14;
  localparam int unsigned GLYPH_BITS = GLYPH_SIZE * GLYPH_SIZE;
  localparam int unsigned CNT_W      = $clog2(GLYPH_BITS);

  localparam logic [7:0]       NEWLINE_CODE    = 8'd10;
  localparam logic [CFG_W-1:0] WIDTH_RESET     = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET    = 12'd480;
  localparam logic [CFG_W-1:0] MAX_PX          = CFG_W'(MAX_SCREEN_PX);

  // register indexes on the config port
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef struct packed {
    logic load_in;   // latch the accepted word, fix up the cursor
    logic prep;      // compute the base offset of the glyph cell
    logic emit_px;   // push one pixel write into the output register
    logic emit_nl;   // push the newline result
  } tcgw_cmd_t;

  typedef struct packed {
    logic in_is_nl;  // the word on the input is a newline
    logic can_load;  // output register free or being drained
    logic last_px;   // current pixel is the last of the glyph
  } tcgw_status_t;

endpackage

[design/tcgw_if.sv]
interface tcgw_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic [63:0] glyph_bits;

  modport source (output valid, output char_code, output glyph_bits, input ready);
  modport sink (input valid, input char_code, input glyph_bits, output ready);
endinterface

interface tcgw_out_if;
  logic        valid;
  logic        ready;
  logic        scroll_first;
  logic        write_valid;
  logic [23:0] pixel_offset;
  logic        pixel_white;
  logic        last;

  modport source (output valid, output scroll_first, output write_valid,
                  output pixel_offset, output pixel_white, output last,
                  input ready);
  modport sink (input valid, input scroll_first, input write_valid,
                input pixel_offset, input pixel_white, input last,
                output ready);
endinterface

[design/tcgw_ctrl.sv]
module tcgw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tcgw_pkg::tcgw_status_t sts,
  output tcgw_pkg::tcgw_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DRAW = 4'b0100,
    S_NL   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.in_is_nl ? S_NL : S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DRAW;
      end
      S_DRAW: begin
        cmd.emit_px = sts.can_load;
        if (sts.can_load && sts.last_px) begin
          state_nxt = S_IDLE;
        end
      end
      S_NL: begin
        cmd.emit_nl = sts.can_load;
        if (sts.can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[design/tcgw_dp.sv]
module tcgw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [tcgw_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [7:0]                    in_char_code,
  input  logic [63:0]                   in_glyph_bits,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_scroll_first,
  output logic                          out_write_valid,
  output logic [tcgw_pkg::OFF_W-1:0]    out_pixel_offset,
  output logic                          out_pixel_white,
  output logic                          out_last,
  input  tcgw_pkg::tcgw_cmd_t           cmd,
  output tcgw_pkg::tcgw_status_t        sts
);

  localparam int unsigned CW = tcgw_pkg::CFG_W;
  localparam int unsigned RW = tcgw_pkg::ROW_W;
  localparam int unsigned LW = tcgw_pkg::COL_W;
  localparam int unsigned OW = tcgw_pkg::OFF_W;
  localparam int unsigned PW = tcgw_pkg::PITCH_W;
  localparam int unsigned KW = tcgw_pkg::CNT_W;

  logic [CW-1:0] width_r, height_r;
  logic [LW-1:0] cursor_col_r;
  logic [RW-1:0] cursor_row_r;
  logic [LW-1:0] col_eff_r;
  logic          scroll_r;
  logic [63:0]   glyph_r;
  logic [KW-1:0] cnt_r;
  logic [OW-1:0] colbase_r, cur_r;

  logic          ov_r;
  logic          o_scroll_r, o_wv_r, o_white_r, o_last_r;
  logic [OW-1:0] o_off_r;

  // screen geometry from the size registers
  logic [CW-1:0] sat_w, sat_h;
  logic [RW-1:0] cols, rows;
  logic [PW-1:0] pitch;
  logic          row_ge, col_ge;
  logic [RW-1:0] row_adj;
  logic [LW-1:0] col_adj;
  logic [RW:0]   col_inc;
  logic [21:0]   row_prod;
  logic [OW-1:0] base;
  logic [OW-1:0] colbase_inc;

  always_comb begin
    sat_w = (width_r  > tcgw_pkg::MAX_PX) ? tcgw_pkg::MAX_PX : width_r;
    sat_h = (height_r > tcgw_pkg::MAX_PX) ? tcgw_pkg::MAX_PX : height_r;
    cols  = (sat_w[CW-1:3] == '0) ? RW'(1) : sat_w[CW-1:3];
    rows  = (sat_h[CW-1:3] == '0) ? RW'(1) : sat_h[CW-1:3];
    pitch = {2'b00, sat_w} + {1'b0, sat_w, 1'b0};

    row_ge  = cursor_row_r >= rows;
    row_adj = row_ge ? (rows - RW'(1)) : cursor_row_r;
    col_ge  = {1'b0, cursor_col_r} >= cols;
    col_adj = col_ge ? LW'(cols - RW'(1)) : cursor_col_r;

    // top-left byte of the cell: row*8*pitch + col*8*3
    row_prod = 22'(cursor_row_r * pitch[12:0]);
    base     = OW'({row_prod, 3'b000}) + OW'({col_eff_r, 4'b0000})
             + OW'({col_eff_r, 3'b000});

    colbase_inc = colbase_r + OW'(tcgw_pkg::PIXEL_BYTES);
    col_inc     = {1'b0, col_eff_r} + (RW+1)'(1);
  end

  assign sts.in_is_nl = (in_char_code == tcgw_pkg::NEWLINE_CODE);
  assign sts.can_load = !ov_r || out_ready;
  assign sts.last_px  = &cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= tcgw_pkg::WIDTH_RESET;
      height_r     <= tcgw_pkg::HEIGHT_RESET;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      ov_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tcgw_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
          tcgw_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (cmd.load_in) begin
        cursor_row_r <= row_adj;
      end else if (cmd.emit_nl) begin
        cursor_col_r <= '0;
        cursor_row_r <= cursor_row_r + RW'(1);
      end else if (cmd.emit_px && (&cnt_r)) begin
        if (col_inc >= {1'b0, cols}) begin
          cursor_col_r <= '0;
          cursor_row_r <= cursor_row_r + RW'(1);
        end else begin
          cursor_col_r <= col_inc[LW-1:0];
        end
      end

      if (cmd.emit_px || cmd.emit_nl) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      glyph_r   <= in_glyph_bits;
      scroll_r  <= row_ge;
      col_eff_r <= col_adj;
    end
    if (cmd.prep) begin
      colbase_r <= base;
      cur_r     <= base;
      cnt_r     <= '0;
    end else if (cmd.emit_px) begin
      cnt_r <= cnt_r + KW'(1);
      // column-major walk: down the column, then to the top of the next
      if (&cnt_r[2:0]) begin
        colbase_r <= colbase_inc;
        cur_r     <= colbase_inc;
      end else begin
        cur_r <= cur_r + OW'(pitch);
      end
    end

    if (cmd.emit_px) begin
      o_scroll_r <= (cnt_r == '0) && scroll_r;
      o_wv_r     <= 1'b1;
      o_off_r    <= cur_r;
      o_white_r  <= glyph_r[{cnt_r[2:0], cnt_r[5:3]}];
      o_last_r   <= &cnt_r;
    end else if (cmd.emit_nl) begin
      o_scroll_r <= scroll_r;
      o_wv_r     <= 1'b0;
      o_off_r    <= '0;
      o_white_r  <= 1'b0;
      o_last_r   <= 1'b1;
    end
  end

  assign out_valid        = ov_r;
  assign out_scroll_first = o_scroll_r;
  assign out_write_valid  = o_wv_r;
  assign out_pixel_offset = o_off_r;
  assign out_pixel_white  = o_white_r;
  assign out_last         = o_last_r;

endmodule

[design/text_console_glyph_writer_core.sv]
// After a character is accepted, S_PREP computes the base offset by a multiply and
// S_DRAW pushes the glyph's 64 pixel words through the single output register;
// a newline is one newline word. The input reopens once the last word is loaded.
// The one output register paces the pixel walk; a stalled out_ch stalls it.
// Reset (rst_n low, synchronous): cursor to column 0 row 0, width 640, height 480,
// output word dropped.
module text_console_glyph_writer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  tcgw_in_if.sink                    in_ch,
  tcgw_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [tcgw_pkg::CFG_W-1:0] cfg_wdata
);

  tcgw_pkg::tcgw_cmd_t    cmd;
  tcgw_pkg::tcgw_status_t sts;

  tcgw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcgw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_char_code     (in_ch.char_code),
    .in_glyph_bits    (in_ch.glyph_bits),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_scroll_first (out_ch.scroll_first),
    .out_write_valid  (out_ch.write_valid),
    .out_pixel_offset (out_ch.pixel_offset),
    .out_pixel_white  (out_ch.pixel_white),
    .out_last         (out_ch.last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

[design/tcgw_checker.sv]
module tcgw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_write_valid,
  input logic        out_pixel_white,
  input logic        out_last,
  input logic [23:0] out_pixel_offset
);

  // held result must not disappear under backpressure
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // one character at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a character");

  // newline word carries no pixel
  a_newline_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_last && !out_pixel_white &&
      (out_pixel_offset == 24'd0))
    else $error("malformed newline word");

  // mid-glyph the input stays closed
  a_mid_glyph_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid && !out_last |-> !in_ready)
    else $error("input reopened before the glyph finished");

endmodule

bind text_console_glyph_writer_core tcgw_checker u_tcgw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_write_valid  (out_ch.write_valid),
  .out_pixel_white  (out_ch.pixel_white),
  .out_last         (out_ch.last),
  .out_pixel_offset (out_ch.pixel_offset)
);
